// ===== hdl/cubic_bezier_uniform_sampler_macros.svh =====
// Assertion macros for the cubic Bezier sampler; used by the issue module.
`ifndef CUBIC_BEZIER_UNIFORM_SAMPLER_MACROS_SVH
`define CUBIC_BEZIER_UNIFORM_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BZS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BZS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bzs_pkg.sv =====
// Shared constants and types for the cubic Bezier sampler.
package bzs_pkg;

    localparam int DEF_MAX_LEVEL  = 5;
    localparam int DEF_COORD_BITS = 16;
    localparam int LEVEL_BITS     = 3;
    localparam int STEP_BITS      = 6;
    localparam int NUM_AXES       = 3;
    localparam int NUM_CTRL       = 4;

    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 3'd3;

    // Per-point control information that travels with each pipeline word.
    typedef struct packed {
        logic [STEP_BITS-1:0]  j;
        logic [STEP_BITS-1:0]  a;
        logic [LEVEL_BITS-1:0] lv;
        logic                  last;
    } pt_meta_t;

endpackage

// ===== hdl/bzs_issue.sv =====
// Segment register and sample counter: issues one curve point per cycle while out_ready is high.
`include "cubic_bezier_uniform_sampler_macros.svh"

module bzs_issue #(
    parameter int COORD_BITS = bzs_pkg::DEF_COORD_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [12*COORD_BITS-1:0]               seg_ctrl,
    input  logic [bzs_pkg::LEVEL_BITS-1:0]         lv_eff,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [12*COORD_BITS-1:0]               out_ctrl,
    output bzs_pkg::pt_meta_t                      out_meta
);
    import bzs_pkg::*;

    localparam int CTRL_W = NUM_CTRL * NUM_AXES * COORD_BITS;

    logic                  busy_reg, busy_next;
    logic [STEP_BITS-1:0]  j_reg, j_next;
    logic [LEVEL_BITS-1:0] lv_reg;
    logic [CTRL_W-1:0]     ctrl_reg;
    logic [STEP_BITS-1:0]  n_pts;
    logic                  is_last;
    logic                  accept;

    // Number of intervals for the latched level, and the final-sample flag.
    assign n_pts   = STEP_BITS'(1) << lv_reg;
    assign is_last = (j_reg == n_pts);

    // A new segment is taken when idle, or while the previous one issues its last point.
    assign s_tready = !busy_reg || (out_ready && is_last);
    assign accept   = s_tvalid && s_tready;

    // Counter and busy flag next values.
    always_comb
    begin
        busy_next = busy_reg;
        j_next    = j_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            j_next    = '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (is_last)
                busy_next = 1'b0;
            else
                j_next = j_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            j_reg    <= '0;
            lv_reg   <= LEVEL_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            j_reg    <= j_next;
            if (accept)
                lv_reg <= lv_eff;
        end
    end

    // Control points are held for the whole segment.
    always_ff @(posedge clk)
    begin
        if (accept)
            ctrl_reg <= seg_ctrl;
    end

    assign out_valid     = busy_reg;
    assign out_ctrl      = ctrl_reg;
    assign out_meta.j    = j_reg;
    assign out_meta.a    = n_pts - j_reg;
    assign out_meta.lv   = lv_reg;
    assign out_meta.last = is_last;

    `BZS_ASSERT_SAME(a_j_in_range, busy_reg, j_reg <= n_pts, "sample index beyond segment end")
    `BZS_ASSERT_NEXT(a_accept_starts, accept, busy_reg && (j_reg == '0), "segment did not start at zero")
    `BZS_ASSERT_NEXT(a_step_advances, busy_reg && out_ready && !is_last && !accept, busy_reg && (j_reg == $past(j_reg) + 1'b1), "sample index did not advance")

endmodule

// ===== hdl/bzs_weight.sv =====
// Two pipeline stages that form the four Bernstein weights for a sample.
module bzs_weight #(
    parameter int COORD_BITS = bzs_pkg::DEF_COORD_BITS,
    parameter int MAX_LEVEL  = bzs_pkg::DEF_MAX_LEVEL
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [12*COORD_BITS-1:0]                      in_ctrl,
    input  bzs_pkg::pt_meta_t                             in_meta,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [12*COORD_BITS-1:0]                      out_ctrl,
    output bzs_pkg::pt_meta_t                             out_meta,
    output logic [3:0][3*MAX_LEVEL:0]                     out_w
);
    import bzs_pkg::*;

    localparam int CTRL_W = NUM_CTRL * NUM_AXES * COORD_BITS;
    localparam int WB     = 3 * MAX_LEVEL + 1;
    localparam int SQW    = 2 * STEP_BITS;
    localparam int CUW    = 3 * STEP_BITS;

    logic              vb_reg, vc_reg;
    logic              rdy_b, rdy_c;
    logic [CTRL_W-1:0] ctrl_b_reg, ctrl_c_reg;
    pt_meta_t          meta_b_reg, meta_c_reg;
    logic [SQW-1:0]    aa_reg, jj_reg, ja_reg;
    logic [SQW-1:0]    aa_next, jj_next, ja_next;
    logic [CUW-1:0]    t0, t1, t2, t3;
    logic [3:0][WB-1:0] w_reg, w_next;

    assign rdy_c    = !vc_reg || out_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign in_ready = rdy_b;

    // Stage B: squares and the cross product of j and n-j.
    assign aa_next = SQW'(in_meta.a) * SQW'(in_meta.a);
    assign jj_next = SQW'(in_meta.j) * SQW'(in_meta.j);
    assign ja_next = SQW'(in_meta.j) * SQW'(in_meta.a);

    // Stage C: cubes, with the factor of three on the inner weights.
    always_comb
    begin
        t0 = CUW'(aa_reg) * CUW'(meta_b_reg.a);
        t1 = CUW'(ja_reg) * CUW'(meta_b_reg.a);
        t2 = CUW'(ja_reg) * CUW'(meta_b_reg.j);
        t3 = CUW'(jj_reg) * CUW'(meta_b_reg.j);
        w_next[0] = WB'(t0);
        w_next[1] = WB'(t1 + (t1 << 1));
        w_next[2] = WB'(t2 + (t2 << 1));
        w_next[3] = WB'(t3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_b)
                vb_reg <= in_valid;
            if (rdy_c)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b && in_valid)
        begin
            ctrl_b_reg <= in_ctrl;
            meta_b_reg <= in_meta;
            aa_reg     <= aa_next;
            jj_reg     <= jj_next;
            ja_reg     <= ja_next;
        end
        if (rdy_c && vb_reg)
        begin
            ctrl_c_reg <= ctrl_b_reg;
            meta_c_reg <= meta_b_reg;
            w_reg      <= w_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_ctrl  = ctrl_c_reg;
    assign out_meta  = meta_c_reg;
    assign out_w     = w_reg;

endmodule

// ===== hdl/bzs_mac.sv =====
// Weighted sum of the control points with rounding: three pipeline stages.
module bzs_mac #(
    parameter int COORD_BITS = bzs_pkg::DEF_COORD_BITS,
    parameter int MAX_LEVEL  = bzs_pkg::DEF_MAX_LEVEL
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [12*COORD_BITS-1:0]              in_ctrl,
    input  bzs_pkg::pt_meta_t                     in_meta,
    input  logic [3:0][3*MAX_LEVEL:0]             in_w,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [3*COORD_BITS-1:0]               out_pt,
    output bzs_pkg::pt_meta_t                     out_meta
);
    import bzs_pkg::*;

    localparam int WB   = 3 * MAX_LEVEL + 1;
    localparam int PW   = COORD_BITS + WB + 1;
    localparam int SUMW = PW + 2;
    localparam int SHW  = LEVEL_BITS + 2;

    logic     vd_reg, ve_reg, vf_reg;
    logic     rdy_d, rdy_e, rdy_f;
    pt_meta_t meta_d_reg, meta_e_reg, meta_f_reg;

    logic signed [PW-1:0]   prod_reg [NUM_AXES][NUM_CTRL];
    logic signed [SUMW-1:0] s01_reg [NUM_AXES];
    logic signed [SUMW-1:0] s23_reg [NUM_AXES];
    logic [SHW-1:0]         sh_e, sh_f;
    logic [SUMW-1:0]        bias;
    logic [3*COORD_BITS-1:0] pt_reg;

    assign rdy_f    = !vf_reg || out_ready;
    assign rdy_e    = !ve_reg || rdy_f;
    assign rdy_d    = !vd_reg || rdy_e;
    assign in_ready = rdy_d;

    // Shift for the division by n cubed, and half of n cubed for rounding.
    assign sh_e = (SHW'(meta_d_reg.lv) << 1) + SHW'(meta_d_reg.lv);
    assign bias = SUMW'(1) << (sh_e - 1'b1);
    assign sh_f = (SHW'(meta_e_reg.lv) << 1) + SHW'(meta_e_reg.lv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else
        begin
            if (rdy_d)
                vd_reg <= in_valid;
            if (rdy_e)
                ve_reg <= vd_reg;
            if (rdy_f)
                vf_reg <= ve_reg;
        end
    end

    // Meta data follows its word through the stages.
    always_ff @(posedge clk)
    begin
        if (rdy_d && in_valid)
            meta_d_reg <= in_meta;
        if (rdy_e && vd_reg)
            meta_e_reg <= meta_d_reg;
        if (rdy_f && ve_reg)
            meta_f_reg <= meta_e_reg;
    end

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_axis
        logic signed [SUMW-1:0] total;
        logic signed [SUMW-1:0] quot;

        // Stage D: one product per control point on this axis.
        for (genvar k = 0; k < NUM_CTRL; k++)
        begin : g_ctrl
            always_ff @(posedge clk)
            begin
                if (rdy_d && in_valid)
                    prod_reg[i][k] <= PW'($signed(in_ctrl[(3*k+i)*COORD_BITS +: COORD_BITS]))
                                    * PW'($signed({1'b0, in_w[k]}));
            end
        end

        // Stage E: pairwise sums, the rounding bias folded into the second.
        always_ff @(posedge clk)
        begin
            if (rdy_e && vd_reg)
            begin
                s01_reg[i] <= SUMW'(prod_reg[i][0]) + SUMW'(prod_reg[i][1]);
                s23_reg[i] <= SUMW'(prod_reg[i][2]) + SUMW'(prod_reg[i][3])
                            + $signed(bias);
            end
        end

        // Stage F: final sum and floor division by n cubed.
        assign total = s01_reg[i] + s23_reg[i];
        assign quot  = total >>> sh_f;

        always_ff @(posedge clk)
        begin
            if (rdy_f && ve_reg)
                pt_reg[i*COORD_BITS +: COORD_BITS] <= quot[COORD_BITS-1:0];
        end
    end

    assign out_valid = vf_reg;
    assign out_pt    = pt_reg;
    assign out_meta  = meta_f_reg;

endmodule

// ===== hdl/cubic_bezier_uniform_sampler.sv =====
// Top level of the cubic Bezier uniform sampler.
// Each accepted word holds one cubic Bezier segment; for level L the block sends
// 2^L+1 points (nine at the reset level of three) at t = j/2^L, one output word
// per cycle while m_tready is high, and the next segment is taken in the cycle its
// last point is issued. A point passes from the issue register through two weight
// stages, product, partial sum and final sum with rounding. Levels of zero read as
// one and levels above MAX_LEVEL read as MAX_LEVEL; the level is latched when a
// segment is taken.
module cubic_bezier_uniform_sampler #(
    parameter int MAX_LEVEL  = bzs_pkg::DEF_MAX_LEVEL,
    parameter int COORD_BITS = bzs_pkg::DEF_COORD_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   level_we,
    input  logic [bzs_pkg::LEVEL_BITS-1:0]         level_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z, c3_x, c3_y, c3_z
    input  logic [((12*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // pt_x, pt_y, pt_z, step_index, zero padding
    output logic [((3*COORD_BITS+6+7)/8)*8-1:0]    m_tdata,
    output logic                                   m_tlast
);
    import bzs_pkg::*;

    localparam int CTRL_W = NUM_CTRL * NUM_AXES * COORD_BITS;
    localparam int WB     = 3 * MAX_LEVEL + 1;

    logic [LEVEL_BITS-1:0] level_reg;
    logic [LEVEL_BITS-1:0] lv_eff;

    logic              iss_valid, iss_ready;
    logic [CTRL_W-1:0] iss_ctrl;
    pt_meta_t          iss_meta;

    logic              wt_valid, wt_ready;
    logic [CTRL_W-1:0] wt_ctrl;
    pt_meta_t          wt_meta;
    logic [3:0][WB-1:0] wt_w;

    logic [3*COORD_BITS-1:0] pt;
    pt_meta_t                pt_meta;

    // Level register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= LEVEL_RESET;
        else if (level_we)
            level_reg <= level_wdata;
    end

    // Clamp the level into the supported range.
    always_comb
    begin
        if (level_reg == '0)
            lv_eff = LEVEL_BITS'(1);
        else if (level_reg > LEVEL_BITS'(MAX_LEVEL))
            lv_eff = LEVEL_BITS'(MAX_LEVEL);
        else
            lv_eff = level_reg;
    end

    bzs_issue #(
        .COORD_BITS (COORD_BITS)
    ) u_issue (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .seg_ctrl  (s_tdata[CTRL_W-1:0]),
        .lv_eff    (lv_eff),
        .out_valid (iss_valid),
        .out_ready (iss_ready),
        .out_ctrl  (iss_ctrl),
        .out_meta  (iss_meta)
    );

    bzs_weight #(
        .COORD_BITS (COORD_BITS),
        .MAX_LEVEL  (MAX_LEVEL)
    ) u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iss_valid),
        .in_ready  (iss_ready),
        .in_ctrl   (iss_ctrl),
        .in_meta   (iss_meta),
        .out_valid (wt_valid),
        .out_ready (wt_ready),
        .out_ctrl  (wt_ctrl),
        .out_meta  (wt_meta),
        .out_w     (wt_w)
    );

    bzs_mac #(
        .COORD_BITS (COORD_BITS),
        .MAX_LEVEL  (MAX_LEVEL)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wt_valid),
        .in_ready  (wt_ready),
        .in_ctrl   (wt_ctrl),
        .in_meta   (wt_meta),
        .in_w      (wt_w),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pt    (pt),
        .out_meta  (pt_meta)
    );

    // Pack the output word.
    always_comb
    begin
        m_tdata = '0;
        m_tdata[3*COORD_BITS-1:0] = pt;
        m_tdata[3*COORD_BITS +: STEP_BITS] = pt_meta.j;
    end

    assign m_tlast = pt_meta.last;

endmodule
